>>> hdl/bmp_pixel_stream_decoder_top_macros.svh
// Assertion macros for the pixel stream decoder.
`ifndef BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH
`define BMP_PIXEL_STREAM_DECODER_TOP_MACROS_SVH

`ifndef SYNTHESIS
`define BMPD_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmpd: same-cycle check failed");
`define BMPD_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmpd: next-cycle check failed");
`else
`define BMPD_ASSERT_IMP(name, clk, rst, ante, cons)
`define BMPD_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

>>> hdl/bmpd_pkg.sv
package bmpd_pkg;

  localparam int COORD_BITS_DEFAULT  = 16;
  localparam int QUEUE_DEPTH_DEFAULT = 2;

  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 16;

  localparam int ROW_BITS = 16;
  localparam int COL_BITS = 17;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DECODE_MODE  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic [7:0] ESC_END_OF_LINE    = 8'd0;
  localparam logic [7:0] ESC_END_OF_PICTURE = 8'd1;
  localparam logic [7:0] ESC_DELTA          = 8'd2;

  localparam logic [7:0] NIBBLE_MASK = 8'd15;

  typedef enum logic [1:0] {
    MODE_RAW8 = 2'd0,
    MODE_RAW4 = 2'd1,
    MODE_RLE8 = 2'd2,
    MODE_RLE4 = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    PH_CMD = 5'b00001,
    PH_VAL = 5'b00010,
    PH_DX  = 5'b00100,
    PH_DY  = 5'b01000,
    PH_ABS = 5'b10000
  } phase_t;

  typedef struct packed {
    logic                      valid;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;
  } cfg_wr_t;

  typedef struct packed {
    logic [ROW_BITS-1:0] row;
    logic [COL_BITS-1:0] col_start;
    logic [7:0]          run_length;
    logic [7:0]          pixel_first;
    logic [7:0]          pixel_second;
    logic                clipped;
    logic                picture_done;
  } res_t;

endpackage

>>> hdl/bmpd_queue.sv
module bmpd_queue import bmpd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  logic [7:0] push_data,
  output logic       pop_valid,
  input  logic       pop_ready,
  output logic [7:0] pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> hdl/bmpd_engine.sv
module bmpd_engine import bmpd_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  input  cfg_wr_t    cfg,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] byte_data,
  output logic       result_valid,
  input  logic       result_ready,
  output res_t       result
);

  localparam int COL_W  = COORD_BITS + 1;
  localparam int ROW_W  = COORD_BITS + 1;
  localparam int DIFF_W = COORD_BITS + 2;

  mode_t                    mode;
  logic [COORD_BITS-1:0]    width_reg;
  logic [COORD_BITS-1:0]    height_reg;

  phase_t                   phase, phase_next;
  logic [COL_W-1:0]         column, column_next;
  logic signed [ROW_W-1:0]  row_pos, row_next;
  logic [7:0]               remaining, remaining_next;
  logic [7:0]               held, held_next;
  logic                     group, group_next;
  logic [COORD_BITS-1:0]    byte_idx, byte_idx_next;
  logic                     finished, finished_next;

  logic [COORD_BITS-1:0]    w_eff;
  logic [COORD_BITS-1:0]    h_eff;
  logic [COORD_BITS-1:0]    h_new;
  logic [COORD_BITS-1:0]    h_new_eff;
  logic [COORD_BITS-1:0]    last_byte;
  logic [COL_W-1:0]         pair_col;
  logic                     cfg_listed;
  logic                     step;
  logic                     rle4;
  logic [7:0]               hi_nib;
  logic [7:0]               lo_nib;

  logic [7:0]               len;
  logic [COL_W-1:0]         col;
  logic [7:0]               pa;
  logic [7:0]               pb;
  logic                     done;
  logic                     eol_req;
  logic                     cmd_end;
  logic                     eol;
  logic signed [DIFF_W-1:0] dy_diff;
  logic                     row_clip;
  logic                     col_clip;
  logic                     emit;
  res_t                     res_next;

  assign w_eff     = (width_reg == '0) ? COORD_BITS'(1) : width_reg;
  assign h_eff     = (height_reg == '0) ? COORD_BITS'(1) : height_reg;
  assign h_new     = (cfg.index == REG_IMAGE_HEIGHT) ? cfg.data[COORD_BITS-1:0] : height_reg;
  assign h_new_eff = (h_new == '0) ? COORD_BITS'(1) : h_new;
  assign last_byte = (mode == MODE_RAW8) ? ((w_eff - COORD_BITS'(1)) | COORD_BITS'(3))
                                         : (((w_eff - COORD_BITS'(1)) >> 1) | COORD_BITS'(3));
  assign pair_col  = {byte_idx, 1'b0};
  assign cfg_listed = (cfg.index == REG_DECODE_MODE) || (cfg.index == REG_IMAGE_WIDTH) ||
                      (cfg.index == REG_IMAGE_HEIGHT);
  assign byte_ready = !result_valid || result_ready;
  assign step       = byte_valid && byte_ready;
  assign rle4       = (mode == MODE_RLE4);
  assign hi_nib     = {4'b0000, byte_data[7:4]};
  assign lo_nib     = byte_data & NIBBLE_MASK;

  always_comb begin
    phase_next     = phase;
    column_next    = column;
    row_next       = row_pos;
    remaining_next = remaining;
    held_next      = held;
    group_next     = group;
    byte_idx_next  = byte_idx;
    finished_next  = finished;
    len     = '0;
    col     = '0;
    pa      = '0;
    pb      = '0;
    done    = 1'b0;
    eol_req = 1'b0;
    cmd_end = 1'b0;
    dy_diff = DIFF_W'(row_pos) - DIFF_W'($signed({1'b0, byte_data}));

    if (!finished) begin
      unique case (mode) inside
        MODE_RAW8, MODE_RAW4: begin
          if (mode == MODE_RAW8) begin
            if (byte_idx < w_eff) begin
              len = 8'd1;
              col = COL_W'(byte_idx);
              pa  = byte_data;
              pb  = byte_data;
            end
          end else begin
            if (pair_col < COL_W'(w_eff)) begin
              len = ((pair_col + COL_W'(1)) < COL_W'(w_eff)) ? 8'd2 : 8'd1;
              col = pair_col;
              pa  = hi_nib;
              pb  = lo_nib;
            end
          end
          if (byte_idx >= last_byte) begin
            byte_idx_next = '0;
            eol_req       = 1'b1;
          end else begin
            byte_idx_next = byte_idx + COORD_BITS'(1);
          end
        end
        MODE_RLE8, MODE_RLE4: begin
          unique case (phase)
            PH_CMD: begin
              held_next  = byte_data;
              phase_next = PH_VAL;
            end
            PH_VAL: begin
              phase_next = PH_CMD;
              if (held != 8'd0) begin
                len         = held;
                col         = column;
                pa          = rle4 ? hi_nib : byte_data;
                pb          = rle4 ? lo_nib : byte_data;
                column_next = column + COL_W'(held);
                cmd_end     = 1'b1;
              end else if (byte_data == ESC_END_OF_LINE) begin
                eol_req = 1'b1;
              end else if (byte_data == ESC_END_OF_PICTURE) begin
                finished_next = 1'b1;
                done          = 1'b1;
              end else if (byte_data == ESC_DELTA) begin
                phase_next = PH_DX;
              end else begin
                remaining_next = byte_data;
                group_next     = 1'b0;
                phase_next     = PH_ABS;
              end
            end
            PH_DX: begin
              column_next = column + COL_W'(byte_data);
              phase_next  = PH_DY;
            end
            PH_DY: begin
              row_next   = (dy_diff < -1) ? '1 : ROW_W'(dy_diff);
              phase_next = PH_CMD;
              cmd_end    = 1'b1;
            end
            PH_ABS: begin
              if (remaining != 8'd0) begin
                len = (rle4 && remaining != 8'd1) ? 8'd2 : 8'd1;
                col = column;
                pa  = rle4 ? hi_nib : byte_data;
                pb  = rle4 ? lo_nib : byte_data;
                column_next    = column + COL_W'(len);
                remaining_next = remaining - len;
              end
              group_next = !group;
              if (remaining_next == 8'd0 && group) begin
                phase_next = PH_CMD;
                cmd_end    = 1'b1;
              end
            end
            default: begin
              phase_next = PH_CMD;
            end
          endcase
        end
        default: begin
          phase_next = PH_CMD;
        end
      endcase
    end

    eol = eol_req || (cmd_end && (column_next > COL_W'(w_eff)));
    if (eol) begin
      column_next = '0;
      if (row_next > 0) begin
        row_next = row_next - ROW_W'(1);
      end else begin
        row_next      = '1;
        finished_next = 1'b1;
        done          = 1'b1;
      end
    end
  end

  assign row_clip = row_pos[ROW_W-1] || (row_pos[COORD_BITS-1:0] >= h_eff);
  assign col_clip = ((COL_W+1)'(col) + (COL_W+1)'(len)) > (COL_W+1)'(w_eff);
  assign emit     = !finished && ((len != 8'd0) || done);

  always_comb begin
    if (len != 8'd0) begin
      res_next.row          = ROW_BITS'(row_clip ? (h_eff - COORD_BITS'(1))
                                                 : row_pos[COORD_BITS-1:0]);
      res_next.col_start    = COL_BITS'(col);
      res_next.run_length   = len;
      res_next.pixel_first  = pa;
      res_next.pixel_second = pb;
      res_next.clipped      = row_clip || col_clip;
      res_next.picture_done = done;
    end else begin
      res_next              = '0;
      res_next.picture_done = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_RAW8;
      width_reg  <= COORD_BITS'(1);
      height_reg <= COORD_BITS'(1);
      phase      <= PH_CMD;
      column     <= '0;
      row_pos    <= '0;
      remaining  <= '0;
      held       <= '0;
      group      <= 1'b0;
      byte_idx   <= '0;
      finished   <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_DECODE_MODE:  mode       <= mode_t'(cfg.data[1:0]);
        REG_IMAGE_WIDTH:  width_reg  <= cfg.data[COORD_BITS-1:0];
        REG_IMAGE_HEIGHT: height_reg <= cfg.data[COORD_BITS-1:0];
        default: ;
      endcase
      if (cfg_listed) begin
        phase     <= PH_CMD;
        column    <= '0;
        row_pos   <= {1'b0, h_new_eff - COORD_BITS'(1)};
        remaining <= '0;
        held      <= '0;
        group     <= 1'b0;
        byte_idx  <= '0;
        finished  <= 1'b0;
      end
    end else if (step) begin
      phase     <= phase_next;
      column    <= column_next;
      row_pos   <= row_next;
      remaining <= remaining_next;
      held      <= held_next;
      group     <= group_next;
      byte_idx  <= byte_idx_next;
      finished  <= finished_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (byte_ready) begin
      result_valid <= step && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      result <= res_next;
    end
  end

endmodule

>>> hdl/bmp_pixel_stream_decoder_top.sv
// Channel   Handshake                  Payload
// stream    stream_valid/stream_ready  stream_byte
// result    result_valid/result_ready  row, col_start, run_length, pixel_first,
//                                      pixel_second, clipped, picture_done
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One byte per cycle sustained while results are drained; the decode stage decodes
// each queued byte as it takes it and registers any result in the output register.
// The decode stage advances whenever the output register is empty or being drained.
// Reset and any write to a listed register return decoding to row height-1, column 0.
// A stalled result holds; the byte queue keeps taking input until it is full.
`include "bmp_pixel_stream_decoder_top_macros.svh"

module bmp_pixel_stream_decoder_top import bmpd_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      stream_valid,
  output logic                      stream_ready,
  input  logic [7:0]                stream_byte,
  output logic                      result_valid,
  input  logic                      result_ready,
  output logic [ROW_BITS-1:0]       row,
  output logic [COL_BITS-1:0]       col_start,
  output logic [7:0]                run_length,
  output logic [7:0]                pixel_first,
  output logic [7:0]                pixel_second,
  output logic                      clipped,
  output logic                      picture_done,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_wr_t    cfg;
  logic       q_valid;
  logic       q_ready;
  logic [7:0] q_data;
  res_t       res;
  logic       empty_run;
  logic       completion_clean;
  logic       result_take;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  bmpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (stream_valid),
    .push_ready (stream_ready),
    .push_data  (stream_byte),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  bmpd_engine #(
    .COORD_BITS (COORD_BITS)
  ) u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .byte_valid   (q_valid),
    .byte_ready   (q_ready),
    .byte_data    (q_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (res)
  );

  assign row          = res.row;
  assign col_start    = res.col_start;
  assign run_length   = res.run_length;
  assign pixel_first  = res.pixel_first;
  assign pixel_second = res.pixel_second;
  assign clipped      = res.clipped;
  assign picture_done = res.picture_done;

  assign empty_run        = result_valid && (run_length == 8'd0);
  assign completion_clean = picture_done && (row == '0) && (col_start == '0) && !clipped &&
                            (pixel_first == 8'd0) && (pixel_second == 8'd0);
  assign result_take      = result_valid && result_ready;

  `BMPD_ASSERT_IMP(a_empty_run_is_completion, clk, rst, empty_run, completion_clean)
  `BMPD_ASSERT_IMP(a_full_queue_feeds_engine, clk, rst, !stream_ready, q_valid)
  `BMPD_ASSERT_NXT(a_silent_after_picture, clk, rst, result_take && picture_done, !result_valid)

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench import bmpd_pkg::*;;

  localparam int ITEM_TARGET = 1150;
  localparam int QUIET_TAIL  = 150;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 2'd3;

  logic                      clk;
  logic                      rst = 1'b1;
  logic                      stream_valid = 1'b0;
  logic                      stream_ready;
  logic [7:0]                stream_byte = 8'd0;
  logic                      result_valid;
  logic                      result_ready = 1'b0;
  logic [ROW_BITS-1:0]       row;
  logic [COL_BITS-1:0]       col_start;
  logic [7:0]                run_length;
  logic [7:0]                pixel_first;
  logic [7:0]                pixel_second;
  logic                      clipped;
  logic                      picture_done;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

  bmp_pixel_stream_decoder_top dut (
    .clk(clk),
    .rst(rst),
    .stream_valid(stream_valid),
    .stream_ready(stream_ready),
    .stream_byte(stream_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .row(row),
    .col_start(col_start),
    .run_length(run_length),
    .pixel_first(pixel_first),
    .pixel_second(pixel_second),
    .clipped(clipped),
    .picture_done(picture_done),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  logic [7:0] byte_backlog[$];
  res_t       expected_runs[$];

  int live_bytes = 0;
  int runs_checked = 0;
  int mismatches = 0;
  int settings_done = 0;
  bit gaps_on = 1'b1;
  int gap_pct = 0;
  int stall_pct = 0;
  int feed_hold = 0;
  int drain_hold = 0;

  // decoder state as the block should hold it
  mode_t  dec_mode;
  int     img_w;
  int     img_h;
  phase_t cmd_phase;
  int     col_pos;
  int     row_pos;
  int     run_left;
  int     cmd_count;
  bit     byte_parity;
  int     row_bytes;
  bit     pic_done;

  function automatic void restart_decoder();
    cmd_phase   = PH_CMD;
    col_pos     = 0;
    row_pos     = ((img_h == 0) ? 1 : img_h) - 1;
    run_left    = 0;
    cmd_count   = 0;
    byte_parity = 1'b0;
    row_bytes   = 0;
    pic_done    = 1'b0;
  endfunction

  function automatic bit next_row();
    col_pos = 0;
    if (row_pos > 0) begin
      row_pos--;
    end else begin
      row_pos  = -1;
      pic_done = 1'b1;
    end
    return pic_done;
  endfunction

  function automatic bit line_overrun(input int w);
    if (col_pos > w) return next_row();
    return 1'b0;
  endfunction

  function automatic bit decode_byte(input logic [7:0] b, output res_t r);
    int w, h, row_now, len, col, pa, pb, bpr, n, cap;
    bit done, nib;
    w       = (img_w == 0) ? 1 : img_w;
    h       = (img_h == 0) ? 1 : img_h;
    row_now = row_pos;
    len     = 0;
    col     = 0;
    pa      = 0;
    pb      = 0;
    done    = 1'b0;
    nib     = (dec_mode == MODE_RLE4);
    cap     = nib ? 2 : 1;
    r       = '0;
    if (pic_done) return 1'b0;
    if (dec_mode == MODE_RAW8 || dec_mode == MODE_RAW4) begin
      if (dec_mode == MODE_RAW8) begin
        bpr = ((w + 3) / 4) * 4;
        if (row_bytes < w) begin
          len = 1;
          col = row_bytes;
          pa  = b;
          pb  = b;
        end
      end else begin
        bpr = ((w + 7) / 8) * 4;
        if (2 * row_bytes < w) begin
          col = 2 * row_bytes;
          len = (w - col >= 2) ? 2 : 1;
          pa  = b >> 4;
          pb  = b & NIBBLE_MASK;
        end
      end
      if (row_bytes >= bpr - 1) begin
        row_bytes = 0;
        done      = next_row();
      end else begin
        row_bytes = (row_bytes + 1) & 16'hFFFF;
      end
    end else begin
      case (cmd_phase)
        PH_CMD: begin
          cmd_count = b;
          cmd_phase = PH_VAL;
        end
        PH_VAL: begin
          cmd_phase = PH_CMD;
          if (cmd_count > 0) begin
            len     = cmd_count;
            col     = col_pos;
            pa      = nib ? (b >> 4) : b;
            pb      = nib ? (b & NIBBLE_MASK) : b;
            col_pos = col_pos + cmd_count;
            done    = line_overrun(w);
          end else if (b == ESC_END_OF_LINE) begin
            done = next_row();
          end else if (b == ESC_END_OF_PICTURE) begin
            pic_done = 1'b1;
            done     = 1'b1;
          end else if (b == ESC_DELTA) begin
            cmd_phase = PH_DX;
          end else begin
            run_left    = b;
            byte_parity = 1'b0;
            cmd_phase   = PH_ABS;
          end
        end
        PH_DX: begin
          col_pos   = col_pos + int'(b);
          cmd_phase = PH_DY;
        end
        PH_DY: begin
          row_pos = row_pos - int'(b);
          if (row_pos < -1) row_pos = -1;
          cmd_phase = PH_CMD;
          done      = line_overrun(w);
        end
        PH_ABS: begin
          n = (run_left < cap) ? run_left : cap;
          if (n > 0) begin
            len      = n;
            col      = col_pos;
            pa       = nib ? (b >> 4) : b;
            pb       = nib ? (b & NIBBLE_MASK) : b;
            col_pos  = col_pos + n;
            run_left = run_left - n;
          end
          byte_parity = ~byte_parity;
          if (run_left == 0 && !byte_parity) begin
            cmd_phase = PH_CMD;
            done      = line_overrun(w);
          end
        end
        default: cmd_phase = PH_CMD;
      endcase
    end
    if (len == 0 && !done) return 1'b0;
    if (len == 0) begin
      r.picture_done = 1'b1;
      return 1'b1;
    end
    if (row_now < 0 || row_now >= h) begin
      r.row     = ROW_BITS'(h - 1);
      r.clipped = 1'b1;
    end else begin
      r.row = ROW_BITS'(row_now);
    end
    if (col + len - 1 >= w) r.clipped = 1'b1;
    r.col_start    = COL_BITS'(col);
    r.run_length   = 8'(len);
    r.pixel_first  = 8'(pa);
    r.pixel_second = 8'(pb);
    r.picture_done = done;
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
      mismatches++;
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stream driver: predict on each accepted transaction, then offer the next byte
  always @(posedge clk) begin
    res_t nxt;
    if (rst) begin
      stream_valid <= 1'b0;
    end else begin
      if (stream_valid && stream_ready) begin
        if (!pic_done) live_bytes++;
        if (decode_byte(stream_byte, nxt)) expected_runs.push_back(nxt);
      end
      if (!stream_valid || stream_ready) begin
        if (feed_hold > 0) begin
          feed_hold--;
          stream_valid <= 1'b0;
        end else if (byte_backlog.size() > 0 &&
                     !(gaps_on && $urandom_range(0, 99) < gap_pct)) begin
          stream_valid <= 1'b1;
          stream_byte  <= byte_backlog.pop_front();
        end else begin
          stream_valid <= 1'b0;
          if (byte_backlog.size() > 0) feed_hold = $urandom_range(0, 3);
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_runs.size() == 0) begin
          $display("%0t ns: result with none expected, row %0d col %0d length %0d",
                   $time, row, col_start, run_length);
          mismatches++;
        end else begin
          want = expected_runs.pop_front();
          runs_checked++;
          check_field("row", want.row, row);
          check_field("col_start", want.col_start, col_start);
          check_field("run_length", want.run_length, run_length);
          check_field("pixel_first", want.pixel_first, pixel_first);
          check_field("pixel_second", want.pixel_second, pixel_second);
          check_field("clipped", want.clipped, clipped);
          check_field("picture_done", want.picture_done, picture_done);
        end
      end
      if (drain_hold > 0) begin
        drain_hold--;
        result_ready <= 1'b0;
      end else if (gaps_on && $urandom_range(0, 99) < stall_pct) begin
        result_ready <= 1'b0;
        drain_hold = $urandom_range(0, 3);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic wait_idle();
    @(negedge clk);
    while (byte_backlog.size() != 0 || stream_valid || expected_runs.size() != 0)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_DECODE_MODE: begin
        dec_mode = mode_t'(val[1:0]);
        restart_decoder();
      end
      REG_IMAGE_WIDTH: begin
        img_w = val;
        restart_decoder();
      end
      REG_IMAGE_HEIGHT: begin
        img_h = val;
        restart_decoder();
      end
      default: ;
    endcase
  endtask

  task automatic apply_setting(input mode_t m, input logic [15:0] w, input logic [15:0] h);
    int first;
    logic [15:0] mode_word;
    first     = $urandom_range(0, 2);
    mode_word = 16'($urandom);
    mode_word[1:0] = m;
    for (int k = 0; k < 3; k++) begin
      case ((first + k) % 3)
        0: write_reg(REG_DECODE_MODE, mode_word);
        1: write_reg(REG_IMAGE_WIDTH, w);
        default: write_reg(REG_IMAGE_HEIGHT, h);
      endcase
      if ($urandom_range(0, 7) == 0) write_reg(REG_UNUSED, 16'($urandom));
    end
    settings_done++;
    @(negedge clk);
  endtask

  task automatic queue_bytes(input logic [7:0] seq[]);
    foreach (seq[i]) byte_backlog.push_back(seq[i]);
  endtask

  task automatic queue_raw_picture(input bit nib, input int w_eff, input int h_eff,
                                   input int budget);
    longint total;
    int bpr;
    bpr   = nib ? ((w_eff + 7) / 8) * 4 : ((w_eff + 3) / 4) * 4;
    total = longint'(bpr) * h_eff + $urandom_range(0, 2);
    if (total > budget) total = budget;
    repeat (int'(total)) byte_backlog.push_back(8'($urandom));
  endtask

  task automatic queue_rle_picture(input bit nib, input int w_eff, input int budget);
    int start, n, nbytes;
    start = byte_backlog.size();
    while (byte_backlog.size() - start < budget) begin
      case ($urandom_range(0, 9)) inside
        [0:3]: begin
          n = $urandom_range(1, (w_eff < 16) ? w_eff + 2 : 40);
          if ($urandom_range(0, 19) == 0) n = 255;
          byte_backlog.push_back(8'(n));
          byte_backlog.push_back(8'($urandom));
        end
        [4:6]: begin
          n = $urandom_range(3, 24);
          if ($urandom_range(0, 29) == 0) n = 255;
          nbytes = nib ? (n + 1) / 2 : n;
          byte_backlog.push_back(ESC_END_OF_LINE);
          byte_backlog.push_back(8'(n));
          repeat (nbytes + (nbytes % 2)) byte_backlog.push_back(8'($urandom));
        end
        7: begin
          byte_backlog.push_back(ESC_END_OF_LINE);
          byte_backlog.push_back(ESC_END_OF_LINE);
        end
        8: begin
          byte_backlog.push_back(ESC_END_OF_LINE);
          byte_backlog.push_back(ESC_DELTA);
          byte_backlog.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 4)));
          byte_backlog.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                             : 8'($urandom_range(0, 1)));
        end
        default: byte_backlog.push_back(8'($urandom));
      endcase
    end
    byte_backlog.push_back(ESC_END_OF_LINE);
    byte_backlog.push_back(ESC_END_OF_PICTURE);
    repeat ($urandom_range(0, 2)) byte_backlog.push_back(8'($urandom));
  endtask

  function automatic logic [15:0] pick_size(input int typical_max);
    case ($urandom_range(0, 11))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3:       return 16'($urandom);
      default: return 16'($urandom_range(1, typical_max));
    endcase
  endfunction

  initial begin
    mode_t m;
    logic [15:0] w, h;
    int w_eff, h_eff, budget;
    dec_mode = MODE_RAW8;
    img_w    = 1;
    img_h    = 1;
    restart_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    gap_pct   = 20;
    stall_pct = 20;

    // reset settings: one pixel, raw 8-bit, padding then completion, then ignored
    queue_bytes('{8'hFF, 8'h00, 8'hA5, 8'h5A, 8'h3C});
    wait_idle();
    // run past the width, delta below row zero, clipped run ending the picture
    apply_setting(MODE_RLE8, 16'd4, 16'd2);
    queue_bytes('{8'h05, 8'hAA, 8'h00, 8'h02, 8'h03, 8'h05, 8'h02, 8'h77, 8'h00});
    wait_idle();
    // zero width, odd absolute run, end-of-picture escape
    apply_setting(MODE_RLE4, 16'd0, 16'd2);
    queue_bytes('{8'h00, 8'h03, 8'h12, 8'h30, 8'h00, 8'h01, 8'hFF});
    wait_idle();
    // one column left in the row, then padding
    apply_setting(MODE_RAW4, 16'd3, 16'd1);
    queue_bytes('{8'hF0, 8'h0F, 8'hC3, 8'h3C});

    while (live_bytes < ITEM_TARGET) begin
      wait_idle();
      gaps_on = (live_bytes < ITEM_TARGET - QUIET_TAIL);
      m = mode_t'($urandom_range(0, 3));
      w = pick_size(12);
      h = pick_size(8);
      apply_setting(m, w, h);
      case ($urandom_range(0, 2))
        0:       gap_pct = 0;
        1:       gap_pct = 10;
        default: gap_pct = 35;
      endcase
      case ($urandom_range(0, 2))
        0:       stall_pct = 0;
        1:       stall_pct = 10;
        default: stall_pct = 35;
      endcase
      w_eff  = (w == 0) ? 1 : w;
      h_eff  = (h == 0) ? 1 : h;
      budget = $urandom_range(20, 150);
      if (m == MODE_RAW8 || m == MODE_RAW4)
        queue_raw_picture(m == MODE_RAW4, w_eff, h_eff, budget);
      else
        queue_rle_picture(m == MODE_RLE4, w_eff, budget);
    end
    wait_idle();

    $display("Checked %0d pixel runs from %0d decoded bytes over %0d register settings",
             runs_checked, live_bytes, settings_done);
    $display("All four decode modes, sizes from zero to 65535, %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d results outstanding", expected_runs.size());
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bmpd_pkg.sv
hdl/bmpd_queue.sv
hdl/bmpd_engine.sv
hdl/bmp_pixel_stream_decoder_top.sv
bench/testbench.sv
